/* hdl/pba_pkg.sv */
// ----------------------------------------------------------------------------
// Pooled buffer allocator package
// Shared constants, payload types, codes and helpers for the allocator core.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int NODES_PER_TRUNK = 64;
   localparam int MAX_TRUNKS      = 64;
   localparam int TOTAL_NODES     = NODES_PER_TRUNK * MAX_TRUNKS;

   localparam int NODE_W  = $clog2(TOTAL_NODES);
   localparam int LINK_W  = NODE_W + 1;
   localparam int SLOT_W  = $clog2(NODES_PER_TRUNK);
   localparam int TRUNK_W = $clog2(MAX_TRUNKS);
   localparam int FILL_W  = $clog2(NODES_PER_TRUNK + 1);

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(TOTAL_NODES);

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_DFREE   = 2'd2,
      FUNC_RECLAIM = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_NO_SPACE   = 3'd1,
      STAT_NO_IDLE    = 3'd2,
      STAT_TARGET_BIG = 3'd3,
      STAT_NONE       = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_FREE,
      ST_POP_DELAY,
      ST_ACTIVATE,
      ST_SWEEP,
      ST_REF_UP,
      ST_CHECK,
      ST_LINK_TAIL,
      ST_WALK_RD,
      ST_WALK_STEP,
      ST_WALK_END,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] node;
      logic [15:0] delay;
      logic [31:0] now;
      logic [6:0]  retire_goal;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] granted_node;
      logic [6:0]  reclaimed_count;
      logic [12:0] used_nodes;
      logic [12:0] active_nodes;
      logic [12:0] delayed_nodes;
      logic [6:0]  active_trunks;
      logic [6:0]  busy_trunks;
   } rsp_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] refs;
   } trunk_entry_type;

   // Link values at or above the pool size read as the end of a list.
   function automatic logic [LINK_W-1:0] clamp_link(input logic [LINK_W-1:0] v);
      clamp_link = (v >= NIL_LINK) ? NIL_LINK : v;
   endfunction

endpackage

/* hdl/pba_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

/* hdl/pooled_buffer_allocator_core.sv */
// ----------------------------------------------------------------------------
// Pooled buffer allocator core
// Free-list pool of node handles grouped in trunks, with a delayed-free queue.
// ----------------------------------------------------------------------------
// Each item runs through a chain of states from the accepting edge to the
// result strobe. A delayed free behind a queue tail also passes ST_LINK_TAIL;
// an alloc that activates a trunk, directly or after a queue head not yet due,
// sweeps one link per node of its fill. A reclaim walk visits every node on
// the free and delayed lists; a rejected reclaim answers at once. One item is in
// work at a time; busy drops in the strobe cycle. Results cannot be stalled.
// Reset (synchronous) empties both lists, clears all trunks and counters.
module pooled_buffer_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pba_pkg::req_type req_data,
   output logic             rsp_valid,
   output pba_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [12:0]      csr_write_data
);
   import pba_pkg::*;

   // Control state and counters.
   state_type               state_ff, state_in;
   logic [LINK_W-1:0]       free_head_ff, free_head_in;
   logic [LINK_W-1:0]       delay_head_ff, delay_head_in;
   logic [LINK_W-1:0]       delay_tail_ff, delay_tail_in;
   logic [12:0]             used_ff, used_in;
   logic [12:0]             active_ff, active_in;
   logic [12:0]             delayed_ff, delayed_in;
   logic [6:0]              on_ff, on_in;
   logic [6:0]              busy_cnt_ff, busy_cnt_in;
   logic [12:0]             limit_ff, limit_in;
   logic [MAX_TRUNKS-1:0]   valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   req_type                 req_ff, req_in;
   logic [2:0]              status_ff, status_in;
   logic [11:0]             granted_ff, granted_in;
   logic [6:0]              count_ff, count_in;
   logic [LINK_W-1:0]       cur_ff, cur_in;
   logic [LINK_W-1:0]       prev_ff, prev_in;
   logic [LINK_W-1:0]       steps_ff, steps_in;
   logic [LINK_W-1:0]       kept_ff, kept_in;
   logic                    done_ff, done_in;
   logic                    list_ff, list_in;
   logic [FILL_W-1:0]       sweep_ff, sweep_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic [TRUNK_W-1:0]      tsel_ff, tsel_in;
   rsp_type                 rsp_ff, rsp_in;

   // Memory ports.
   logic                    link_we;
   logic [NODE_W-1:0]       link_waddr, link_raddr;
   logic [LINK_W-1:0]       link_wdata, link_rdata;
   logic                    time_we;
   logic [NODE_W-1:0]       time_waddr, time_raddr;
   logic [31:0]             time_wdata, time_rdata;
   logic                    trunk_we;
   logic [TRUNK_W-1:0]      trunk_waddr, trunk_raddr;
   trunk_entry_type         trunk_wdata, trunk_rdata;

   // Lowest inactive trunk, for activation.
   logic [TRUNK_W-1:0]      free_trunk;
   logic                    free_trunk_found;

   always_comb begin
      free_trunk       = '0;
      free_trunk_found = 1'b0;
      for (int i = MAX_TRUNKS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_trunk       = TRUNK_W'(i);
            free_trunk_found = 1'b1;
         end
      end
   end

   // The link store holds the next pointer of every node on either list.
   pba_ram #(.WIDTH(LINK_W), .DEPTH(TOTAL_NODES)) u_link_ram (
      .clock         (clock),
      .write_enable  (link_we),
      .write_address (link_waddr),
      .write_data    (link_wdata),
      .read_address  (link_raddr),
      .read_data     (link_rdata)
   );

   // Release times of nodes waiting in the delayed-free queue.
   pba_ram #(.WIDTH(32), .DEPTH(TOTAL_NODES)) u_time_ram (
      .clock         (clock),
      .write_enable  (time_we),
      .write_address (time_waddr),
      .write_data    (time_wdata),
      .read_address  (time_raddr),
      .read_data     (time_rdata)
   );

   // Fill and reference count of each trunk. An entry is only used while its
   // trunk is active, and activation always writes it first.
   pba_ram #(.WIDTH(2 * FILL_W), .DEPTH(MAX_TRUNKS)) u_trunk_ram (
      .clock         (clock),
      .write_enable  (trunk_we),
      .write_address (trunk_waddr),
      .write_data    (trunk_wdata),
      .read_address  (trunk_raddr),
      .read_data     (trunk_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= NIL_LINK;
         delay_head_ff <= NIL_LINK;
         delay_tail_ff <= NIL_LINK;
         used_ff       <= '0;
         active_ff     <= '0;
         delayed_ff    <= '0;
         on_ff         <= '0;
         busy_cnt_ff   <= '0;
         limit_ff      <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         delay_head_ff <= delay_head_in;
         delay_tail_ff <= delay_tail_in;
         used_ff       <= used_in;
         active_ff     <= active_in;
         delayed_ff    <= delayed_in;
         on_ff         <= on_in;
         busy_cnt_ff   <= busy_cnt_in;
         limit_ff      <= limit_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      count_ff   <= count_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      steps_ff   <= steps_in;
      kept_ff    <= kept_in;
      done_ff    <= done_in;
      list_ff    <= list_in;
      sweep_ff   <= sweep_in;
      fill_ff    <= fill_in;
      tsel_ff    <= tsel_in;
      rsp_ff     <= rsp_in;
   end

   // Next state and datapath. Every memory access is read in one cycle and
   // written in a later one, so a read never meets a write to the same entry.
   always_comb begin
      logic [6:0]          idle;
      logic [12:0]         room;
      logic [FILL_W-1:0]   fill;
      logic [LINK_W-1:0]   nxt;
      logic [TRUNK_W-1:0]  t;
      logic                keep;
      logic [FILL_W-1:0]   refs_dec;
      logic [NODE_W-1:0]   base;

      state_in      = state_ff;
      free_head_in  = free_head_ff;
      delay_head_in = delay_head_ff;
      delay_tail_in = delay_tail_ff;
      used_in       = used_ff;
      active_in     = active_ff;
      delayed_in    = delayed_ff;
      on_in         = on_ff;
      busy_cnt_in   = busy_cnt_ff;
      limit_in      = csr_write_enable ? csr_write_data : limit_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      req_in        = req_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      kept_in       = kept_ff;
      done_in       = done_ff;
      list_in       = list_ff;
      sweep_in      = sweep_ff;
      fill_in       = fill_ff;
      tsel_in       = tsel_ff;
      rsp_in        = rsp_ff;

      link_we     = 1'b0;
      link_waddr  = '0;
      link_wdata  = '0;
      link_raddr  = '0;
      time_we     = 1'b0;
      time_waddr  = '0;
      time_wdata  = '0;
      time_raddr  = '0;
      trunk_we    = 1'b0;
      trunk_waddr = '0;
      trunk_wdata = '0;
      trunk_raddr = '0;

      idle     = (on_ff > busy_cnt_ff) ? on_ff - busy_cnt_ff : 7'd0;
      room     = limit_ff - active_ff;
      fill     = '0;
      nxt      = clamp_link(link_rdata);
      t        = cur_ff[NODE_W-1:SLOT_W];
      keep     = 1'b0;
      refs_dec = trunk_rdata.refs - FILL_W'(1);
      base     = {tsel_ff, SLOT_W'(0)};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               status_in  = STAT_OK;
               granted_in = '0;
               count_in   = '0;
               unique case (func_type'(req_data.func))
                  FUNC_ALLOC: begin
                     if (!free_head_ff[NODE_W]) begin
                        link_raddr = free_head_ff[NODE_W-1:0];
                        state_in   = ST_POP_FREE;
                     end else if (!delay_head_ff[NODE_W]) begin
                        link_raddr = delay_head_ff[NODE_W-1:0];
                        time_raddr = delay_head_ff[NODE_W-1:0];
                        state_in   = ST_POP_DELAY;
                     end else begin
                        state_in = ST_ACTIVATE;
                     end
                  end
                  FUNC_FREE, FUNC_DFREE: begin
                     trunk_raddr = req_data.node[NODE_W-1:SLOT_W];
                     state_in    = ST_CHECK;
                  end
                  FUNC_RECLAIM: begin
                     if (idle == 7'd0) begin
                        status_in = STAT_NO_IDLE;
                        state_in  = ST_RESP;
                     end else if (req_data.retire_goal != 7'd0 &&
                                  idle < req_data.retire_goal) begin
                        status_in = STAT_TARGET_BIG;
                        state_in  = ST_RESP;
                     end else begin
                        cur_in       = free_head_ff;
                        prev_in      = NIL_LINK;
                        free_head_in = NIL_LINK;
                        steps_in     = '0;
                        done_in      = 1'b0;
                        list_in      = 1'b0;
                        state_in     = ST_WALK_RD;
                     end
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_POP_FREE: begin
            req_in.node  = free_head_ff[NODE_W-1:0];
            free_head_in = nxt;
            trunk_raddr  = free_head_ff[NODE_W-1:SLOT_W];
            state_in     = ST_REF_UP;
         end

         ST_POP_DELAY: begin
            if (time_rdata <= req_ff.now) begin
               req_in.node   = delay_head_ff[NODE_W-1:0];
               delay_head_in = nxt;
               if (delay_tail_ff == delay_head_ff || nxt[NODE_W]) begin
                  delay_tail_in = NIL_LINK;
               end
               if (delayed_ff != 13'd0) begin
                  delayed_in = delayed_ff - 13'd1;
               end
               trunk_raddr = delay_head_ff[NODE_W-1:SLOT_W];
               state_in    = ST_REF_UP;
            end else begin
               state_in = ST_ACTIVATE;
            end
         end

         ST_ACTIVATE: begin
            fill = FILL_W'(NODES_PER_TRUNK);
            if (limit_ff != 13'd0 && room < 13'(NODES_PER_TRUNK)) begin
               fill = room[FILL_W-1:0];
            end
            if (!free_trunk_found ||
                (limit_ff != 13'd0 && active_ff >= limit_ff)) begin
               status_in = STAT_NO_SPACE;
               state_in  = ST_RESP;
            end else begin
               tsel_in  = free_trunk;
               fill_in  = fill;
               sweep_in = '0;
               state_in = ST_SWEEP;
            end
         end

         // One link written per cycle; the last cycle also commits the trunk
         // and hands out its first node.
         ST_SWEEP: begin
            link_we    = 1'b1;
            link_waddr = {tsel_ff, sweep_ff[SLOT_W-1:0]};
            link_wdata = (sweep_ff + FILL_W'(1) < fill_ff) ?
                         LINK_W'({tsel_ff, sweep_ff[SLOT_W-1:0]}) + LINK_W'(1) : NIL_LINK;
            sweep_in   = sweep_ff + FILL_W'(1);
            if (sweep_ff + FILL_W'(1) == fill_ff) begin
               free_head_in      = (fill_ff > FILL_W'(1)) ? LINK_W'(base) + LINK_W'(1)
                                                          : NIL_LINK;
               valid_in[tsel_ff] = 1'b1;
               on_in             = on_ff + 7'd1;
               active_in         = active_ff + 13'(fill_ff);
               trunk_we          = 1'b1;
               trunk_waddr       = tsel_ff;
               trunk_wdata.fill  = fill_ff;
               trunk_wdata.refs  = FILL_W'(1);
               busy_cnt_in       = busy_cnt_ff + 7'd1;
               used_in           = used_ff + 13'd1;
               granted_in        = base;
               state_in          = ST_RESP;
            end
         end

         ST_REF_UP: begin
            trunk_we         = 1'b1;
            trunk_waddr      = req_ff.node[NODE_W-1:SLOT_W];
            trunk_wdata.fill = trunk_rdata.fill;
            trunk_wdata.refs = trunk_rdata.refs + FILL_W'(1);
            if (trunk_rdata.refs == '0) begin
               busy_cnt_in = busy_cnt_ff + 7'd1;
            end
            used_in    = used_ff + 13'd1;
            granted_in = req_ff.node;
            state_in   = ST_RESP;
         end

         ST_CHECK: begin
            state_in = ST_RESP;
            if (valid_ff[req_ff.node[NODE_W-1:SLOT_W]] &&
                FILL_W'(req_ff.node[SLOT_W-1:0]) < trunk_rdata.fill &&
                trunk_rdata.refs != '0) begin
               trunk_we         = 1'b1;
               trunk_waddr      = req_ff.node[NODE_W-1:SLOT_W];
               trunk_wdata.fill = trunk_rdata.fill;
               trunk_wdata.refs = refs_dec;
               if (used_ff != 13'd0) begin
                  used_in = used_ff - 13'd1;
               end
               if (refs_dec == '0 && busy_cnt_ff != 7'd0) begin
                  busy_cnt_in = busy_cnt_ff - 7'd1;
               end
               link_we    = 1'b1;
               link_waddr = req_ff.node;
               if (func_type'(req_ff.func) == FUNC_FREE) begin
                  link_wdata   = free_head_ff;
                  free_head_in = LINK_W'(req_ff.node);
               end else begin
                  link_wdata = NIL_LINK;
                  time_we    = 1'b1;
                  time_waddr = req_ff.node;
                  time_wdata = req_ff.now + 32'(req_ff.delay);
                  delayed_in = delayed_ff + 13'd1;
                  if (delay_head_ff[NODE_W] || delay_tail_ff[NODE_W]) begin
                     delay_head_in = LINK_W'(req_ff.node);
                     delay_tail_in = LINK_W'(req_ff.node);
                  end else begin
                     state_in = ST_LINK_TAIL;
                  end
               end
            end
         end

         // Append to the queue after the node's own link has been cleared.
         ST_LINK_TAIL: begin
            link_we       = 1'b1;
            link_waddr    = delay_tail_ff[NODE_W-1:0];
            link_wdata    = LINK_W'(req_ff.node);
            delay_tail_in = LINK_W'(req_ff.node);
            state_in      = ST_RESP;
         end

         ST_WALK_RD: begin
            if (cur_ff[NODE_W] || steps_ff[NODE_W]) begin
               state_in = ST_WALK_END;
            end else begin
               link_raddr  = cur_ff[NODE_W-1:0];
               trunk_raddr = t;
               state_in    = ST_WALK_STEP;
            end
         end

         // The free list pass retires idle trunks as it meets them, until the retire
         // goal is met; the queue pass keeps only nodes of trunks still active.
         ST_WALK_STEP: begin
            keep = valid_ff[t];
            if (!list_ff) begin
               if (valid_ff[t] && trunk_rdata.refs == '0 && !done_ff) begin
                  valid_in[t] = 1'b0;
                  if (on_ff != 7'd0) begin
                     on_in = on_ff - 7'd1;
                  end
                  active_in = (active_ff >= 13'(trunk_rdata.fill)) ?
                              active_ff - 13'(trunk_rdata.fill) : 13'd0;
                  count_in  = count_ff + 7'd1;
                  if (req_ff.retire_goal != 7'd0 &&
                      count_ff + 7'd1 == req_ff.retire_goal) begin
                     done_in = 1'b1;
                  end
                  keep = 1'b0;
               end
            end else if (keep) begin
               kept_in = kept_ff + LINK_W'(1);
            end
            if (keep) begin
               if (prev_ff[NODE_W]) begin
                  if (!list_ff) begin
                     free_head_in = cur_ff;
                  end else begin
                     delay_head_in = cur_ff;
                  end
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff[NODE_W-1:0];
                  link_wdata = cur_ff;
               end
               prev_in = cur_ff;
            end
            cur_in   = nxt;
            steps_in = steps_ff + LINK_W'(1);
            state_in = ST_WALK_RD;
         end

         ST_WALK_END: begin
            if (!prev_ff[NODE_W]) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[NODE_W-1:0];
               link_wdata = NIL_LINK;
            end
            if (!list_ff) begin
               list_in       = 1'b1;
               cur_in        = delay_head_ff;
               prev_in       = NIL_LINK;
               delay_head_in = NIL_LINK;
               steps_in      = '0;
               kept_in       = '0;
               state_in      = ST_WALK_RD;
            end else begin
               delay_tail_in = prev_ff;
               delayed_in    = kept_ff;
               status_in     = (count_ff != 7'd0) ? STAT_OK : STAT_NONE;
               state_in      = ST_RESP;
            end
         end

         ST_RESP: begin
            rsp_in.status          = status_ff;
            rsp_in.granted_node    = granted_ff;
            rsp_in.reclaimed_count = count_ff;
            rsp_in.used_nodes      = used_ff;
            rsp_in.active_nodes    = active_ff;
            rsp_in.delayed_nodes   = delayed_ff;
            rsp_in.active_trunks   = on_ff;
            rsp_in.busy_trunks     = busy_cnt_ff;
            rsp_valid_in           = 1'b1;
            state_in               = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
